// ----- src/wsdf_pkg.sv -----
// ----------------------------------------------------------------------------
// wsdf_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsdf_pkg;

    // parse phase
    typedef enum logic [1:0] {
        PH_HDR0 = 2'd0,
        PH_LEN  = 2'd1,
        PH_EXT  = 2'd2,
        PH_PAY  = 2'd3
    } t_phase;

    // result kind
    typedef enum logic [1:0] {
        K_HDR_BYTE = 2'd0,
        K_HDR_DONE = 2'd1,
        K_PAYLOAD  = 2'd2,
        K_REJECT   = 2'd3
    } t_kind;

    localparam logic [3:0] OPC_CLOSE    = 4'd8;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;

    // one result transaction
    typedef struct packed {
        t_kind        kind;
        logic         fin;
        logic [2:0]   reserved_bits;
        logic [3:0]   opcode;
        logic [63:0]  payload_length;
        logic [7:0]   data_byte;
        logic         frame_end;
        logic [15:0]  status_code;
        logic         closed;
    } t_result;

endpackage

// ----- src/wsdf_parser.sv -----
// ----------------------------------------------------------------------------
// wsdf_parser
// frame parse state and the per-byte result
// ----------------------------------------------------------------------------
module wsdf_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output wsdf_pkg::t_result o_result
);
    import wsdf_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_ext,    n_ext;
    logic [63:0] r_len,    n_len;
    logic [63:0] r_left,   n_left;
    logic        r_fin,    n_fin;
    logic [2:0]  r_rsv,    n_rsv;
    logic [3:0]  r_opcode, n_opcode;
    logic [15:0] r_close,  n_close;
    logic [1:0]  r_pidx,   n_pidx;
    logic        r_closed, n_closed;

    logic        hdr_done;
    t_kind       kind;
    logic [7:0]  data;
    logic        fend;

    always_comb begin
        n_phase  = r_phase;
        n_ext    = r_ext;
        n_len    = r_len;
        n_left   = r_left;
        n_fin    = r_fin;
        n_rsv    = r_rsv;
        n_opcode = r_opcode;
        n_close  = r_close;
        n_pidx   = r_pidx;
        n_closed = r_closed;
        hdr_done = 1'b0;
        kind     = K_HDR_BYTE;
        data     = 8'd0;
        fend     = 1'b0;

        case (r_phase)
            PH_LEN: begin
                n_len = '0;
                if (i_rx_byte[6:0] == LEN_EXT16) begin
                    n_ext   = EXT_BYTES_16;
                    n_phase = PH_EXT;
                end else if (i_rx_byte[6:0] == LEN_EXT64) begin
                    n_ext   = EXT_BYTES_64;
                    n_phase = PH_EXT;
                end else begin
                    n_len    = {57'd0, i_rx_byte[6:0]};
                    hdr_done = 1'b1;
                end
            end
            PH_EXT: begin
                n_len = {r_len[55:0], i_rx_byte};
                n_ext = r_ext - 4'd1;
                if (n_ext == 4'd0) begin
                    hdr_done = 1'b1;
                end
            end
            PH_PAY: begin
                kind = K_PAYLOAD;
                data = i_rx_byte;
                if (r_opcode == OPC_CLOSE) begin
                    if (r_pidx == 2'd0) begin
                        n_close = {i_rx_byte, 8'd0};
                    end else if (r_pidx == 2'd1) begin
                        n_close = {r_close[15:8], i_rx_byte};
                    end
                end
                if (r_pidx != 2'd2) begin
                    n_pidx = r_pidx + 2'd1;
                end
                n_left = r_left - 64'd1;
                if (n_left == 64'd0) begin
                    fend    = 1'b1;
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                if (r_closed) begin
                    kind = K_REJECT;
                end else begin
                    n_fin    = i_rx_byte[7];
                    n_rsv    = i_rx_byte[6:4];
                    n_opcode = i_rx_byte[3:0];
                    n_len    = '0;
                    n_left   = '0;
                    n_close  = '0;
                    n_pidx   = 2'd0;
                    n_ext    = 4'd0;
                    n_phase  = PH_LEN;
                end
            end
        endcase

        // header complete: latch close, start payload or end empty frame
        if (hdr_done) begin
            kind = K_HDR_DONE;
            if (r_opcode == OPC_CLOSE) begin
                n_closed = 1'b1;
            end
            if (n_len == 64'd0) begin
                fend    = 1'b1;
                n_phase = PH_HDR0;
            end else begin
                n_left  = n_len;
                n_phase = PH_PAY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_ext    <= 4'd0;
            r_len    <= '0;
            r_left   <= '0;
            r_fin    <= 1'b0;
            r_rsv    <= 3'd0;
            r_opcode <= 4'd0;
            r_close  <= 16'd0;
            r_pidx   <= 2'd0;
            r_closed <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_ext    <= n_ext;
            r_len    <= n_len;
            r_left   <= n_left;
            r_fin    <= n_fin;
            r_rsv    <= n_rsv;
            r_opcode <= n_opcode;
            r_close  <= n_close;
            r_pidx   <= n_pidx;
            r_closed <= n_closed;
        end
    end

    always_comb begin
        o_result.kind           = kind;
        o_result.fin            = n_fin;
        o_result.reserved_bits  = n_rsv;
        o_result.opcode         = n_opcode;
        o_result.payload_length = n_len;
        o_result.data_byte      = data;
        o_result.frame_end      = fend;
        o_result.status_code    = n_close;
        o_result.closed         = n_closed;
    end

endmodule

// ----- src/wsdf_out_buf.sv -----
// ----------------------------------------------------------------------------
// wsdf_out_buf
// result register with a skid stage behind it
// ----------------------------------------------------------------------------
module wsdf_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsdf_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output wsdf_pkg::t_result o_result
);
    import wsdf_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop = r_main_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_main_valid || pop) begin
                if (r_skid_valid) begin
                    r_main_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_main_valid <= i_push;
                end
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

endmodule

// ----- src/websocket_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// splits a received byte stream into websocket frames, one result per byte
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_rx_byte
//  out     | output    | o_out_valid / i_out_stall | o_kind .. o_closed (9 fields)
//
//  one byte per cycle sustained while the output does not stall; each input
//  transaction yields exactly one result transaction, set by the parse update
//  reset is synchronous, active low, and returns the parser to the first
//  header byte with the closed flag clear
//  o_in_stall rises only when both the result register and the skid stage
//  hold results; the skid stage takes the transaction accepted during an
//  output stall, and the input is then held until it drains
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // received byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,

    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic        o_fin,
    output logic [2:0]  o_reserved_bits,
    output logic [3:0]  o_opcode,
    output logic [63:0] o_payload_length,
    output logic [7:0]  o_data_byte,
    output logic        o_frame_end,
    output logic [15:0] o_status_code,
    output logic        o_closed
);
    import wsdf_pkg::*;

    logic    in_accept;
    logic    buf_full;
    t_result parse_result;
    t_result out_result;

    // an input transaction is taken whenever the skid stage is free
    assign in_accept  = i_in_valid && !buf_full;
    assign o_in_stall = buf_full;

    // header / length / payload state machine, result worked out in the same cycle
    wsdf_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .o_result  (parse_result)
    );

    // registered result plus skid so that input and output stalls are decoupled
    wsdf_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_result (parse_result),
        .o_full   (buf_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    // unpack the result onto the field ports
    assign o_kind           = out_result.kind;
    assign o_fin            = out_result.fin;
    assign o_reserved_bits  = out_result.reserved_bits;
    assign o_opcode         = out_result.opcode;
    assign o_payload_length = out_result.payload_length;
    assign o_data_byte      = out_result.data_byte;
    assign o_frame_end      = out_result.frame_end;
    assign o_status_code    = out_result.status_code;
    assign o_closed         = out_result.closed;

`ifndef SYNTHESIS
    // skid stage only fills behind a held result
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid stage full while result register empty");

    // a rejected byte only happens once the connection is closed
    a_reject_when_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == K_REJECT) |-> o_closed)
        else $error("byte rejected without closed flag");

    // data byte is zero except on payload results
    a_data_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != K_PAYLOAD) |-> (o_data_byte == 8'd0))
        else $error("data byte set outside payload");

    // frame end only on header complete or payload results
    a_frame_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_kind == K_HDR_DONE || o_kind == K_PAYLOAD))
        else $error("frame end on wrong result kind");
`endif

endmodule

// ----- bench/tb_websocket_frame_deframer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_top
// self-checking bench for the websocket frame deframer: a directed byte table,
// then random frames with random content, and finally one close frame followed
// by bytes that must be rejected. every result is compared field by field with
// a hand-typed row result or an in-bench frame decoder
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_top;
    import wsdf_pkg::*;

    localparam int RANDOM_BYTES    = 400;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int CYCLE_LIMIT     = 300000;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // received byte channel
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;

    // result channel
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic        o_fin;
    logic [2:0]  o_reserved_bits;
    logic [3:0]  o_opcode;
    logic [63:0] o_payload_length;
    logic [7:0]  o_data_byte;
    logic        o_frame_end;
    logic [15:0] o_status_code;
    logic        o_closed;

    websocket_frame_deframer_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_fin            (o_fin),
        .o_reserved_bits  (o_reserved_bits),
        .o_opcode         (o_opcode),
        .o_payload_length (o_payload_length),
        .o_data_byte      (o_data_byte),
        .o_frame_end      (o_frame_end),
        .o_status_code    (o_status_code),
        .o_closed         (o_closed)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // frame decoder state, mirrors the parser inside the block
    // ------------------------------------------------------------------------
    t_phase      ws_phase;
    logic [3:0]  ws_ext_left;
    logic [63:0] ws_length;
    logic [63:0] ws_payload_left;
    logic        ws_fin;
    logic [2:0]  ws_reserved;
    logic [3:0]  ws_opcode;
    logic [15:0] ws_close_status;
    logic [1:0]  ws_payload_index;
    logic        ws_closed;

    // results still owed by the block, oldest first
    t_result expected_parse_results[$];

    // directed byte table; a row either carries a hand-typed result or leaves
    // the expectation to the decoder
    logic [7:0] row_byte[$];
    bit         row_typed[$];
    t_result    row_result[$];

    int fail_count     = 0;
    int bytes_accepted = 0;
    int cycle_count    = 0;

    // idling control shared by the sender and the result sink
    int idle_pct        = 0;
    bit hold_off_req    = 1'b0;
    bit hold_off_active = 1'b0;

    // one received byte through the decoder, state updated in place
    task automatic decode_rx_byte(input logic [7:0] b, output t_result r);
        t_kind      kind;
        logic [7:0] data;
        logic       fend;
        bit         header_done;
        kind        = K_HDR_BYTE;
        data        = 8'h00;
        fend        = 1'b0;
        header_done = 1'b0;
        case (ws_phase)
            PH_LEN: begin
                ws_length = '0;
                if (b[6:0] == LEN_EXT16) begin
                    ws_ext_left = EXT_BYTES_16;
                    ws_phase    = PH_EXT;
                end else if (b[6:0] == LEN_EXT64) begin
                    ws_ext_left = EXT_BYTES_64;
                    ws_phase    = PH_EXT;
                end else begin
                    // mask bit ignored
                    ws_length   = {57'd0, b[6:0]};
                    header_done = 1'b1;
                end
            end
            PH_EXT: begin
                // big-endian, partial value visible while bytes arrive
                ws_length   = {ws_length[55:0], b};
                ws_ext_left = ws_ext_left - 4'd1;
                if (ws_ext_left == 4'd0) header_done = 1'b1;
            end
            PH_PAY: begin
                kind = K_PAYLOAD;
                data = b;
                if (ws_opcode == OPC_CLOSE) begin
                    if (ws_payload_index == 2'd0) ws_close_status = {b, 8'h00};
                    else if (ws_payload_index == 2'd1) ws_close_status = ws_close_status | {8'h00, b};
                end
                if (ws_payload_index < 2'd2) ws_payload_index = ws_payload_index + 2'd1;
                ws_payload_left = ws_payload_left - 64'd1;
                if (ws_payload_left == 64'd0) begin
                    fend     = 1'b1;
                    ws_phase = PH_HDR0;
                end
            end
            default: begin
                if (ws_closed) begin
                    // dropped, nothing changes
                    kind = K_REJECT;
                end else begin
                    ws_fin           = b[7];
                    ws_reserved      = b[6:4];
                    ws_opcode        = b[3:0];
                    ws_length        = '0;
                    ws_payload_left  = '0;
                    ws_close_status  = '0;
                    ws_payload_index = '0;
                    ws_ext_left      = '0;
                    ws_phase         = PH_LEN;
                end
            end
        endcase
        if (header_done) begin
            kind = K_HDR_DONE;
            // close latches at header completion, its payload still passes
            if (ws_opcode == OPC_CLOSE) ws_closed = 1'b1;
            if (ws_length == 64'd0) begin
                fend     = 1'b1;
                ws_phase = PH_HDR0;
            end else begin
                ws_payload_left = ws_length;
                ws_phase        = PH_PAY;
            end
        end
        r.kind           = kind;
        r.fin            = ws_fin;
        r.reserved_bits  = ws_reserved;
        r.opcode         = ws_opcode;
        r.payload_length = ws_length;
        r.data_byte      = data;
        r.frame_end      = fend;
        r.status_code    = ws_close_status;
        r.closed         = ws_closed;
    endtask

    // hand-typed result for directed rows; no close frame is seen there
    function automatic t_result hand_result(t_kind k, logic fin, logic [2:0] rsv,
                                            logic [3:0] opc, logic [63:0] len,
                                            logic [7:0] data, logic fend);
        t_result r;
        r.kind           = k;
        r.fin            = fin;
        r.reserved_bits  = rsv;
        r.opcode         = opc;
        r.payload_length = len;
        r.data_byte      = data;
        r.frame_end      = fend;
        r.status_code    = '0;
        r.closed         = 1'b0;
        return r;
    endfunction

    task automatic add_row(input logic [7:0] b, input bit typed, input t_result r);
        row_byte.push_back(b);
        row_typed.push_back(typed);
        row_result.push_back(r);
    endtask

    // offer one byte, with an optional gap before it, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_result typed_res);
        t_result predicted;
        int      gap;
        @(negedge i_clk);
        if (idle_pct != 0 && !hold_off_active && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 18);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_rx_byte(b, predicted);
        expected_parse_results.push_back(typed ? typed_res : predicted);
        bytes_accepted++;
    endtask

    // one well-formed frame with random header, length encoding and content
    task automatic send_random_frame(input bit closing);
        logic [3:0]  opc;
        logic [63:0] len;
        logic [6:0]  code;
        int          ext_n;
        int          sel;
        opc = closing ? OPC_CLOSE : 4'($urandom_range(0, 15));
        // a close mid-run would end the test early
        if (!closing && opc == OPC_CLOSE) opc = 4'($urandom_range(0, 7));
        sel = $urandom_range(0, 19);
        if (closing) len = 64'($urandom_range(0, 3));
        else if (sel < 12) len = 64'($urandom_range(0, 12));
        else if (sel == 12) len = 64'd125;
        else if (sel == 13) len = 64'($urandom_range(13, 124));
        else if (sel < 18) len = 64'($urandom_range(0, 300));
        else len = 64'($urandom_range(0, 40));
        if (sel >= 18) ext_n = 8;
        else if (sel >= 14) ext_n = 2;
        else ext_n = 0;
        if (ext_n == 8) code = LEN_EXT64;
        else if (ext_n == 2) code = LEN_EXT16;
        else code = len[6:0];
        send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), opc}, 1'b0, '0);
        send_byte({1'($urandom_range(0, 1)), code}, 1'b0, '0);
        for (int i = ext_n - 1; i >= 0; i--) send_byte(len[8*i +: 8], 1'b0, '0);
        for (longint unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // result checker, compares every accepted transaction with the oldest
    // expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_parse_results.size() == 0) begin
                $error("result transaction with nothing expected");
                fail_count++;
            end else begin
                want = expected_parse_results.pop_front();
                check_field("kind", 64'(want.kind), 64'(o_kind));
                check_field("fin", 64'(want.fin), 64'(o_fin));
                check_field("reserved_bits", 64'(want.reserved_bits), 64'(o_reserved_bits));
                check_field("opcode", 64'(want.opcode), 64'(o_opcode));
                check_field("payload_length", want.payload_length, o_payload_length);
                check_field("data_byte", 64'(want.data_byte), 64'(o_data_byte));
                check_field("frame_end", 64'(want.frame_end), 64'(o_frame_end));
                check_field("status_code", 64'(want.status_code), 64'(o_status_code));
                check_field("closed", 64'(want.closed), 64'(o_closed));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result sink: random stall bursts, plus one long hold-off on request so
    // that the block fills and pushes back on the byte channel
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req    = 1'b0;
                hold_off_active = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_off_active = 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                gap = $urandom_range(1, 18);
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : run
        int  start;
        int  n;
        bit  hold_off_issued;
        hold_off_issued = 1'b0;
        i_in_valid      = 1'b0;
        i_rx_byte       = 8'h00;

        // decoder starts from the post-reset state
        ws_phase         = PH_HDR0;
        ws_ext_left      = '0;
        ws_length        = '0;
        ws_payload_left  = '0;
        ws_fin           = 1'b0;
        ws_reserved      = '0;
        ws_opcode        = '0;
        ws_close_status  = '0;
        ws_payload_index = '0;
        ws_closed        = 1'b0;

        // all-zero header and empty frame straight after reset
        add_row(8'h00, 1'b1, hand_result(K_HDR_BYTE, 1'b0, 3'd0, 4'd0, 64'd0, 8'h00, 1'b0));
        add_row(8'h00, 1'b1, hand_result(K_HDR_DONE, 1'b0, 3'd0, 4'd0, 64'd0, 8'h00, 1'b1));
        // all-ones header, masked length of one, all-ones payload byte
        add_row(8'hFF, 1'b1, hand_result(K_HDR_BYTE, 1'b1, 3'd7, 4'd15, 64'd0, 8'h00, 1'b0));
        add_row(8'h81, 1'b1, hand_result(K_HDR_DONE, 1'b1, 3'd7, 4'd15, 64'd1, 8'h00, 1'b0));
        add_row(8'hFF, 1'b1, hand_result(K_PAYLOAD, 1'b1, 3'd7, 4'd15, 64'd1, 8'hFF, 1'b1));
        // 16-bit extended length of zero: header ends the frame
        add_row(8'h82, 1'b0, '0);
        add_row(8'h7E, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h00, 1'b1, hand_result(K_HDR_DONE, 1'b1, 3'd0, 4'd2, 64'd0, 8'h00, 1'b1));
        // 64-bit extended length of two, mask bit set
        add_row(8'h09, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        repeat (7) add_row(8'h00, 1'b0, '0);
        add_row(8'h02, 1'b0, '0);
        add_row(8'hA5, 1'b0, '0);
        add_row(8'h5A, 1'b0, '0);
        // reserved bits set, 16-bit extended length of one
        add_row(8'h71, 1'b0, '0);
        add_row(8'hFE, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h01, 1'b0, '0);
        add_row(8'h3C, 1'b0, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 6;
        foreach (row_byte[i]) send_byte(row_byte[i], row_typed[i], row_result[i]);

        // random frames; idling on, then a clean stretch, then the long
        // hold-off with heavier idling, and none at the tail
        start = bytes_accepted;
        while (bytes_accepted - start < RANDOM_BYTES) begin
            n = bytes_accepted - start;
            if (n < 120) idle_pct = 6;
            else if (n < 180) idle_pct = 0;
            else if (n < 320) idle_pct = 10;
            else idle_pct = 0;
            if (n >= 200 && !hold_off_issued) begin
                hold_off_issued = 1'b1;
                hold_off_req    = 1'b1;
            end
            send_random_frame(1'b0);
        end

        // close frame, then everything after it must be rejected
        idle_pct = 0;
        send_random_frame(1'b1);
        repeat ($urandom_range(20, 40)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (expected_parse_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
